FILE: hdl/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_ROM   = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_BAD   = 2'd3
   } access_kind_type;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [0:0] CSR_ROM_BANK_BITS = 1'd0;
   localparam logic [0:0] CSR_RAM_BANKS     = 1'd1;

   localparam logic [15:0] ENABLE_LAST   = 16'h1FFF;
   localparam logic [15:0] ROM_SEL_LAST  = 16'h3FFF;
   localparam logic [15:0] RAM_SEL_LAST  = 16'h5FFF;
   localparam logic [15:0] MODE_LAST     = 16'h7FFF;
   localparam logic [15:0] SAVE_FIRST    = 16'hA000;
   localparam logic [15:0] SAVE_LAST     = 16'hBFFF;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
   localparam logic [7:0] OPEN_BUS_BYTE  = 8'hFF;

   localparam int RAM_BANK_BYTES   = 8192;
   localparam int RAM_OFFSET_BITS  = 13;
   localparam int RAM_INDEX_BITS   = 15;
   localparam int ROM_OFFSET_BITS  = 14;
   localparam int ROM_BANK_WIDTH   = 7;
   localparam int ROM_ADDR_BITS    = 21;
   localparam int QUEUE_DEPTH      = 2;

   typedef struct packed {
      access_kind_type            kind;
      logic [ROM_ADDR_BITS-1:0]   rom_address;
      logic [RAM_INDEX_BITS-1:0]  ram_index;
      logic                       ram_read;
      logic                       ram_write;
      logic [7:0]                 write_data;
   } queue_entry_type;

endpackage

FILE: hdl/cbc_req_if.sv
// ----------------------------------------------------------------------------
// cbc_req_if
// Request channel: one bus access per transfer.
// ----------------------------------------------------------------------------
interface cbc_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, req_type, address, write_data, input ready);
   modport sink   (input valid, req_type, address, write_data, output ready);
endinterface

FILE: hdl/cbc_rsp_if.sv
// ----------------------------------------------------------------------------
// cbc_rsp_if
// Response channel: one result per accepted request.
// ----------------------------------------------------------------------------
interface cbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  access_kind;
   logic [7:0]  read_data;
   logic [20:0] rom_address;

   modport source (output valid, access_kind, read_data, rom_address, input ready);
   modport sink   (input valid, access_kind, read_data, rom_address, output ready);
endinterface

FILE: hdl/cbc_ram.sv
// ----------------------------------------------------------------------------
// cbc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module cbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

FILE: hdl/cbc_front.sv
// ----------------------------------------------------------------------------
// cbc_front
// Request decode: holds the bank control state and CSRs, classifies each
// request and pushes a decoded entry toward the back end.
// ----------------------------------------------------------------------------
module cbc_front #(
   parameter int RAM_BANK_COUNT = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   cbc_req_if.sink                  req,
   input  logic                     csr_write_enable,
   input  logic [0:0]               csr_index,
   input  logic [2:0]               csr_write_data,
   input  logic                     queue_full,
   output logic                     push,
   output cbc_pkg::queue_entry_type push_entry
);
   import cbc_pkg::*;

   logic       ram_enable_ff, ram_enable_in;
   logic [4:0] rom_bank_select_ff, rom_bank_select_in;
   logic [1:0] ram_bank_select_ff, ram_bank_select_in;
   logic       bank_mode_ff, bank_mode_in;
   logic [2:0] rom_bank_bits_ff, rom_bank_bits_in;
   logic [2:0] ram_banks_ff, ram_banks_in;

   logic [ROM_BANK_WIDTH-1:0] rom_mask;
   logic [ROM_BANK_WIDTH-1:0] rom_bank;
   logic [2:0]                banks_used;
   logic [1:0]                ram_bank_raw;
   logic [1:0]                ram_bank;
   logic                      ram_ok;
   logic [RAM_INDEX_BITS-1:0] ram_index_full;
   logic [15:0]               addr;
   logic [7:0]                data;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;
   assign addr      = req.address;
   assign data      = req.write_data;

   assign rom_mask = ROM_BANK_WIDTH'((8'd1 << rom_bank_bits_ff) - 8'd1);

   always_comb begin
      if (ram_banks_ff > 3'(RAM_BANK_COUNT)) begin
         banks_used = 3'(RAM_BANK_COUNT);
      end else begin
         banks_used = ram_banks_ff;
      end
      ram_bank_raw = bank_mode_ff ? ram_bank_select_ff : 2'd0;
      unique case (banks_used)
         3'd0, 3'd1: ram_bank = 2'd0;
         3'd2:       ram_bank = {1'b0, ram_bank_raw[0]};
         3'd3:       ram_bank = (ram_bank_raw == 2'd3) ? 2'd0 : ram_bank_raw;
         default:    ram_bank = ram_bank_raw;
      endcase
      ram_ok         = (banks_used != 3'd0) && ram_enable_ff;
      ram_index_full = {ram_bank, addr[RAM_OFFSET_BITS-1:0]};
   end

   always_comb begin
      ram_enable_in      = ram_enable_ff;
      rom_bank_select_in = rom_bank_select_ff;
      ram_bank_select_in = ram_bank_select_ff;
      bank_mode_in       = bank_mode_ff;
      rom_bank           = '0;

      push_entry             = '0;
      push_entry.ram_index   = ram_index_full;
      push_entry.write_data  = data;

      if (req.req_type == REQ_WRITE) begin
         push_entry.kind = KIND_WRITE;
         priority if (addr <= ENABLE_LAST) begin
            ram_enable_in = (data[3:0] == RAM_ENABLE_KEY);
         end else if (addr <= ROM_SEL_LAST) begin
            rom_bank_select_in = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
         end else if (addr <= RAM_SEL_LAST) begin
            ram_bank_select_in = data[1:0];
         end else if (addr <= MODE_LAST) begin
            bank_mode_in = data[0];
         end else if (addr >= SAVE_FIRST && addr <= SAVE_LAST) begin
            push_entry.ram_write = ram_ok;
         end else begin
         end
      end else begin
         priority if (addr <= ROM_SEL_LAST) begin
            push_entry.kind = KIND_ROM;
            if (bank_mode_ff) begin
               rom_bank = {ram_bank_select_ff, 5'd0} & rom_mask;
            end
            push_entry.rom_address = {rom_bank, addr[ROM_OFFSET_BITS-1:0]};
         end else if (addr <= MODE_LAST) begin
            push_entry.kind = KIND_ROM;
            rom_bank = {2'd0, rom_bank_select_ff} & rom_mask;
            push_entry.rom_address = {rom_bank, addr[ROM_OFFSET_BITS-1:0]};
         end else if (addr >= SAVE_FIRST && addr <= SAVE_LAST) begin
            push_entry.kind     = KIND_DATA;
            push_entry.ram_read = ram_ok;
         end else begin
            push_entry.kind = KIND_BAD;
         end
      end

      if (!push) begin
         ram_enable_in      = ram_enable_ff;
         rom_bank_select_in = rom_bank_select_ff;
         ram_bank_select_in = ram_bank_select_ff;
         bank_mode_in       = bank_mode_ff;
      end
   end

   always_comb begin
      rom_bank_bits_in = rom_bank_bits_ff;
      ram_banks_in     = ram_banks_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROM_BANK_BITS: rom_bank_bits_in = csr_write_data;
            CSR_RAM_BANKS:     ram_banks_in     = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_enable_ff      <= 1'b0;
         rom_bank_select_ff <= 5'd1;
         ram_bank_select_ff <= 2'd0;
         bank_mode_ff       <= 1'b0;
         rom_bank_bits_ff   <= 3'd1;
         ram_banks_ff       <= 3'd0;
      end else begin
         ram_enable_ff      <= ram_enable_in;
         rom_bank_select_ff <= rom_bank_select_in;
         ram_bank_select_ff <= ram_bank_select_in;
         bank_mode_ff       <= bank_mode_in;
         rom_bank_bits_ff   <= rom_bank_bits_in;
         ram_banks_ff       <= ram_banks_in;
      end
   end

endmodule

FILE: hdl/cbc_queue.sv
// ----------------------------------------------------------------------------
// cbc_queue
// Short FIFO of decoded entries between the front and back ends.
// ----------------------------------------------------------------------------
module cbc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cbc_pkg::queue_entry_type push_entry,
   output logic                     full,
   output logic                     head_valid,
   output cbc_pkg::queue_entry_type head_entry,
   input  logic                     pop
);
   import cbc_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] ptr);
      if (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_BITS'(1);
   endfunction

   assign full       = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + COUNT_BITS'(push) - COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && count_ff == '0))
      else $error("queue popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue pushed while full");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + COUNT_BITS'(1))
      else $error("queue count did not follow push");

endmodule

FILE: hdl/cbc_back.sv
// ----------------------------------------------------------------------------
// cbc_back
// Execution: issues save RAM accesses for queued entries and holds the
// response register.
// ----------------------------------------------------------------------------
module cbc_back #(
   parameter int RAM_BANK_COUNT = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  cbc_pkg::queue_entry_type head_entry,
   output logic                     pop,
   cbc_rsp_if.source                rsp
);
   import cbc_pkg::*;

   localparam int RAM_DEPTH = RAM_BANK_COUNT * RAM_BANK_BYTES;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   logic                     rsp_valid_ff, rsp_valid_in;
   access_kind_type          kind_ff;
   logic [ROM_ADDR_BITS-1:0] rom_address_ff;
   logic                     from_ram_ff;
   logic                     ram_we;
   logic                     ram_re;
   logic [7:0]               ram_q;

   assign pop    = head_valid && (!rsp_valid_ff || rsp.ready);
   assign ram_we = pop && head_entry.ram_write;
   assign ram_re = pop && head_entry.ram_read;

   cbc_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_save_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .read_enable  (ram_re),
      .addr         (head_entry.ram_index[RAM_AW-1:0]),
      .write_data   (head_entry.write_data),
      .read_data    (ram_q)
   );

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff        <= head_entry.kind;
         rom_address_ff <= head_entry.rom_address;
         from_ram_ff    <= head_entry.ram_read;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.access_kind = kind_ff;
   assign rsp.rom_address = rom_address_ff;
   assign rsp.read_data   = (kind_ff != KIND_DATA) ? 8'h00 :
                            (from_ram_ff ? ram_q : OPEN_BUS_BYTE);

   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> rsp_valid_ff && kind_ff == KIND_DATA && from_ram_ff)
      else $error("save RAM read not presented as data response");

   a_write_kind: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> head_entry.kind == KIND_WRITE && !ram_re)
      else $error("save RAM write from a non-write entry");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> !$past(ram_re) || $stable(ram_q))
      else $error("stalled RAM data changed");

endmodule

FILE: hdl/cartridge_bank_controller_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller_core
// Cartridge ROM/RAM bank switcher with decoupled decode and execution.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one CPU bus access per request (read or write, 16-bit
//   address, data byte). rsp_bus returns one result per request, in order:
//   access kind, save RAM byte, and the mapped ROM address for ROM reads.
//   csr_* writes the ROM bank bits and save RAM bank count; write only
//   while no request is outstanding.
//   Path: an accepted request is held in the decode queue, then loaded into
//   the response register alongside the registered save RAM read.
//   Throughput: one request per cycle while rsp_bus is ready; each queued
//   entry is popped once, and save RAM accesses use the single RAM port.
//   A two-entry queue sits between decode and execution; when rsp_bus
//   stalls the response is held and up to two more requests are taken
//   before req_bus ready drops.
//   Reset restores the bank control state and CSR defaults; save RAM
//   contents are undefined until written.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_core #(
   parameter int RAM_BANK_COUNT = 4
) (
   input  logic       clock,
   input  logic       reset,
   cbc_req_if.sink    req_bus,
   cbc_rsp_if.source  rsp_bus,
   input  logic       csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [2:0] csr_write_data
);
   import cbc_pkg::*;

   logic            push;
   queue_entry_type push_entry;
   logic            queue_full;
   logic            head_valid;
   queue_entry_type head_entry;
   logic            pop;

   cbc_front #(
      .RAM_BANK_COUNT (RAM_BANK_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   cbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   cbc_back #(
      .RAM_BANK_COUNT (RAM_BANK_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule
